/* src/asec_pkg.sv */
// Shared types, constants and microcode table for the axial settling envelope check.
// Depends on nothing; every other file of the block imports it.
package asec_pkg;

    // field widths
    localparam int COORD_W = 28;
    localparam int AXIS_W  = 16;
    localparam int LIMIT_W = 27;
    localparam int DELTA_W = COORD_W + 1;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int P_W     = 32;
    localparam int STEP_W  = 4;
    localparam int IDX_W   = 3;

    // Q2.14 rounding of the projection
    localparam int FRAC_BITS = 14;
    localparam int P_LSB     = FRAC_BITS;
    localparam int P_MSB     = FRAC_BITS + P_W - 1;
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(64'sd1 <<< (FRAC_BITS - 1));

    // unit axis value in Q2.14
    localparam logic signed [AXIS_W-1:0] AXIS_ONE = 16'sd16384;

    typedef struct packed {
        logic                      command;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } obs_item_t;

    typedef struct packed {
        logic                      verdict;
        logic signed [COORD_W-1:0] tracked_departure;
    } res_item_t;

    localparam logic CMD_SETTLE = 1'b0;

    // register indexes
    typedef logic [IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_SEED_X         = 3'd0;
    localparam cfg_index_t REG_SEED_Y         = 3'd1;
    localparam cfg_index_t REG_SEED_Z         = 3'd2;
    localparam cfg_index_t REG_AXIS_X         = 3'd3;
    localparam cfg_index_t REG_AXIS_Y         = 3'd4;
    localparam cfg_index_t REG_AXIS_Z         = 3'd5;
    localparam cfg_index_t REG_LATERAL_LIMIT  = 3'd6;
    localparam cfg_index_t REG_SETTLING_LIMIT = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] seed_x;
        logic signed [COORD_W-1:0] seed_y;
        logic signed [COORD_W-1:0] seed_z;
        logic signed [AXIS_W-1:0]  axis_x;
        logic signed [AXIS_W-1:0]  axis_y;
        logic signed [AXIS_W-1:0]  axis_z;
        logic [LIMIT_W-1:0]        lateral_limit;
        logic [LIMIT_W-1:0]        settling_limit;
    } cfg_t;

    // control word fields
    typedef enum logic [2:0] {
        OPA_DX,
        OPA_DY,
        OPA_DZ,
        OPA_P,
        OPA_LIM
    } opa_t;

    typedef enum logic [2:0] {
        OPB_AX,
        OPB_AY,
        OPB_AZ,
        OPB_DX,
        OPB_DY,
        OPB_DZ,
        OPB_P,
        OPB_LIM
    } opb_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_DELTA,
        ACT_ROUND,
        ACT_FINISH
    } act_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        opa_t    a_sel;
        opb_t    b_sel;
        acc_op_t acc_op;
        act_t    action;
        logic    jump_settle;
        step_t   target;
        logic    last;
    } uword_t;

    // sequencer to datapath
    typedef struct packed {
        logic   active;
        uword_t word;
    } ctrl_t;

    localparam step_t STEP_SETTLE = 4'd12;

    // microcode: projection, then either the settle update or the lateral test
    // the query finish step keeps the limit square on the multiplier while it waits
    function automatic uword_t ucode(input step_t step);
        uword_t w;
        case (step)
            4'd0:    w = '{OPA_DX,  OPB_AX,  ACC_HOLD, ACT_DELTA,  1'b0, 4'd0,        1'b0};
            4'd1:    w = '{OPA_DX,  OPB_AX,  ACC_HOLD, ACT_NONE,   1'b0, 4'd0,        1'b0};
            4'd2:    w = '{OPA_DY,  OPB_AY,  ACC_LOAD, ACT_NONE,   1'b0, 4'd0,        1'b0};
            4'd3:    w = '{OPA_DZ,  OPB_AZ,  ACC_ADD,  ACT_NONE,   1'b0, 4'd0,        1'b0};
            4'd4:    w = '{OPA_DX,  OPB_DX,  ACC_ADD,  ACT_NONE,   1'b0, 4'd0,        1'b0};
            4'd5:    w = '{OPA_DX,  OPB_DX,  ACC_HOLD, ACT_ROUND,  1'b1, STEP_SETTLE, 1'b0};
            4'd6:    w = '{OPA_DX,  OPB_DX,  ACC_HOLD, ACT_NONE,   1'b0, 4'd0,        1'b0};
            4'd7:    w = '{OPA_DY,  OPB_DY,  ACC_LOAD, ACT_NONE,   1'b0, 4'd0,        1'b0};
            4'd8:    w = '{OPA_DZ,  OPB_DZ,  ACC_ADD,  ACT_NONE,   1'b0, 4'd0,        1'b0};
            4'd9:    w = '{OPA_P,   OPB_P,   ACC_ADD,  ACT_NONE,   1'b0, 4'd0,        1'b0};
            4'd10:   w = '{OPA_LIM, OPB_LIM, ACC_SUB,  ACT_NONE,   1'b0, 4'd0,        1'b0};
            4'd11:   w = '{OPA_LIM, OPB_LIM, ACC_HOLD, ACT_FINISH, 1'b0, 4'd0,        1'b1};
            4'd12:   w = '{OPA_DX,  OPB_DX,  ACC_HOLD, ACT_FINISH, 1'b0, 4'd0,        1'b1};
            default: w = '{OPA_DX,  OPB_DX,  ACC_HOLD, ACT_NONE,   1'b0, 4'd0,        1'b1};
        endcase
        return w;
    endfunction

endpackage

/* src/axial_settling_envelope_check.sv */
// Top level of the axial settling envelope check: item capture, result register
// and wiring. Depends on asec_pkg, asec_cfg_regs, asec_sequencer, asec_datapath.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  obs      | obs_valid / obs_stall | obs_item: command, pos_x/y/z
//  res      | res_valid / res_stall | res_item: verdict, tracked_departure
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A settle item branches from the projection to the settle update, a query item
// runs on through the lateral test; both run their microcode steps through the single shared 32x32
// multiplier. A new item is taken while the previous result still waits.
// After reset the tracked departure is zero and the axis is +z.
// A stalled result holds the sequencer on its last step until the register frees.
module axial_settling_envelope_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          obs_valid,
    output logic                          obs_stall,
    input  asec_pkg::obs_item_t           obs_item,
    output logic                          res_valid,
    input  logic                          res_stall,
    output asec_pkg::res_item_t           res_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  asec_pkg::cfg_index_t          cfg_index,
    input  logic [asec_pkg::COORD_W-1:0]  cfg_data
);
    import asec_pkg::*;

    cfg_t      cfg;
    ctrl_t     ctrl;
    obs_item_t item_reg;
    res_item_t result;
    res_item_t res_item_reg;
    logic      res_valid_reg;
    logic      start;
    logic      out_free;
    logic      fire;

    assign cfg_ready = 1'b1;
    assign obs_stall = ctrl.active;
    assign start     = obs_valid && !obs_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign fire      = ctrl.active && (ctrl.word.action == ACT_FINISH) && out_free;

    asec_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    asec_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .settle   (item_reg.command == CMD_SETTLE),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    asec_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .item   (item_reg),
        .cfg    (cfg),
        .fire   (fire),
        .result (result)
    );

    // input item capture and result capture
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg <= obs_item;
        end
        if (fire)
        begin
            res_item_reg <= result;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

/* src/asec_cfg_regs.sv */
// Configuration register file of the axial settling envelope check.
// Depends on asec_pkg for the register indexes and the cfg_t bundle.
module asec_cfg_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  asec_pkg::cfg_index_t  wr_index,
    input  logic [asec_pkg::COORD_W-1:0] wr_data,
    output asec_pkg::cfg_t        cfg
);
    import asec_pkg::*;

    cfg_t cfg_reg;

    // register writes by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                <= '{axis_z: AXIS_ONE, default: '0};
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SEED_X:         cfg_reg.seed_x         <= $signed(wr_data);
                REG_SEED_Y:         cfg_reg.seed_y         <= $signed(wr_data);
                REG_SEED_Z:         cfg_reg.seed_z         <= $signed(wr_data);
                REG_AXIS_X:         cfg_reg.axis_x         <= $signed(wr_data[AXIS_W-1:0]);
                REG_AXIS_Y:         cfg_reg.axis_y         <= $signed(wr_data[AXIS_W-1:0]);
                REG_AXIS_Z:         cfg_reg.axis_z         <= $signed(wr_data[AXIS_W-1:0]);
                REG_LATERAL_LIMIT:  cfg_reg.lateral_limit  <= wr_data[LIMIT_W-1:0];
                REG_SETTLING_LIMIT: cfg_reg.settling_limit <= wr_data[LIMIT_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/asec_sequencer.sv */
// Step counter of the microcoded control: fetches one control word per step.
// Depends on asec_pkg for the microcode table and the ctrl_t bundle.
module asec_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            settle,
    input  logic            out_free,
    output asec_pkg::ctrl_t ctrl
);
    import asec_pkg::*;

    logic   active_reg;
    logic   active_next;
    step_t  step_reg;
    step_t  step_next;
    uword_t word;
    logic   hold;

    assign word = ucode(step_reg);
    // the last step waits while the result register is still occupied
    assign hold = (word.action == ACT_FINISH) && !out_free;

    // next step: advance, take the settle branch, or stop
    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        if (!active_reg)
        begin
            if (start)
            begin
                active_next = 1'b1;
                step_next   = '0;
            end
        end
        else if (!hold)
        begin
            if (word.last)
            begin
                active_next = 1'b0;
            end
            else if (word.jump_settle && settle)
            begin
                step_next = word.target;
            end
            else
            begin
                step_next = step_reg + step_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
        end
    end

    assign ctrl.active = active_reg;
    assign ctrl.word   = word;

endmodule

/* src/asec_datapath.sv */
// Datapath: deltas, one shared 32x32 multiplier, accumulator, rounding, compares
// and the tracked departure. Depends on asec_pkg.
module asec_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  asec_pkg::ctrl_t     ctrl,
    input  asec_pkg::obs_item_t item,
    input  asec_pkg::cfg_t      cfg,
    input  logic                fire,
    output asec_pkg::res_item_t result
);
    import asec_pkg::*;

    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] dy_reg;
    logic signed [DELTA_W-1:0] dz_reg;
    logic signed [P_W-1:0]     p_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0]  acc_next;
    logic signed [COORD_W-1:0] deepest_reg;

    logic signed [MUL_W-1:0]   op_a;
    logic signed [MUL_W-1:0]   op_b;
    logic signed [PROD_W-1:0]  rounded_sum;
    logic signed [P_W-1:0]     deep_ext;
    logic signed [P_W:0]       floor_sum;
    logic                      settle_hit;
    logic                      query_hit;
    logic                      is_settle;

    // multiplier operand selection
    always_comb
    begin
        case (ctrl.word.a_sel)
            OPA_DX:  op_a = MUL_W'(dx_reg);
            OPA_DY:  op_a = MUL_W'(dy_reg);
            OPA_DZ:  op_a = MUL_W'(dz_reg);
            OPA_P:   op_a = p_reg;
            OPA_LIM: op_a = $signed(MUL_W'(cfg.lateral_limit));
            default: op_a = '0;
        endcase
    end

    always_comb
    begin
        case (ctrl.word.b_sel)
            OPB_AX:  op_b = MUL_W'(cfg.axis_x);
            OPB_AY:  op_b = MUL_W'(cfg.axis_y);
            OPB_AZ:  op_b = MUL_W'(cfg.axis_z);
            OPB_DX:  op_b = MUL_W'(dx_reg);
            OPB_DY:  op_b = MUL_W'(dy_reg);
            OPB_DZ:  op_b = MUL_W'(dz_reg);
            OPB_P:   op_b = p_reg;
            OPB_LIM: op_b = $signed(MUL_W'(cfg.lateral_limit));
            default: op_b = '0;
        endcase
    end

    // accumulator operation on the previous product
    always_comb
    begin
        case (ctrl.word.acc_op)
            ACC_HOLD: acc_next = acc_reg;
            ACC_LOAD: acc_next = prod_reg;
            ACC_ADD:  acc_next = acc_reg + prod_reg;
            ACC_SUB:  acc_next = acc_reg - prod_reg;
            default:  acc_next = acc_reg;
        endcase
    end

    // round to nearest, ties upward, dropping the 14 fraction bits
    assign rounded_sum = acc_reg + ROUND_BIAS;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (ctrl.active)
        begin
            acc_reg <= acc_next;
            if (ctrl.word.action == ACT_DELTA)
            begin
                dx_reg <= DELTA_W'(item.pos_x) - DELTA_W'(cfg.seed_x);
                dy_reg <= DELTA_W'(item.pos_y) - DELTA_W'(cfg.seed_y);
                dz_reg <= DELTA_W'(item.pos_z) - DELTA_W'(cfg.seed_z);
            end
            if (ctrl.word.action == ACT_ROUND)
            begin
                p_reg <= $signed(rounded_sum[P_MSB:P_LSB]);
            end
        end
    end

    // settle: strictly deeper than tracked, not below minus the settling limit
    assign deep_ext   = P_W'(deepest_reg);
    assign floor_sum  = (P_W + 1)'(p_reg) + $signed((P_W + 1)'(cfg.settling_limit));
    assign settle_hit = (p_reg < deep_ext) && !floor_sum[P_W];

    // query: at or above tracked, lateral squared within limit squared
    // (a negative lateral term is always within, so no clamp is needed)
    assign query_hit  = (p_reg >= deep_ext) && (acc_reg <= prod_reg);

    assign is_settle  = (item.command == CMD_SETTLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deepest_reg <= '0;
        end
        else if (fire && is_settle && settle_hit)
        begin
            deepest_reg <= p_reg[COORD_W-1:0];
        end
    end

    // result of the finishing step
    always_comb
    begin
        if (is_settle)
        begin
            result.verdict           = settle_hit;
            result.tracked_departure = settle_hit ? p_reg[COORD_W-1:0] : deepest_reg;
        end
        else
        begin
            result.verdict           = query_hit;
            result.tracked_departure = deepest_reg;
        end
    end

endmodule
